>>> src/lpfw_pkg.sv
// Shared types and constants for the low-precision float widening unit.
// Has no dependencies; the widening unit and lpfw_lzc import it.
`default_nettype none

package lpfw_pkg;

  // Source element formats, as held in the format register.
  typedef enum logic [1:0] {
    FMT_SINGLE = 2'd0,
    FMT_HALF   = 2'd1,
    FMT_BF16   = 2'd2,
    FMT_UNSUP  = 2'd3
  } fmt_t;

  // Classes of a half-precision element.
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_SUBNORMAL,
    CLS_SPECIAL,
    CLS_NORMAL
  } half_class_t;

  localparam int WORD_W     = 32;
  localparam int HALF_W     = 16;
  localparam int HALF_EXP_W = 5;
  localparam int FRAC_W     = 10;
  localparam int LZC_W      = 4;
  localparam int SGL_EXP_W  = 8;
  localparam int SGL_FRAC_W = 23;

  localparam logic [HALF_EXP_W-1:0] HALF_EXP_MAX  = 5'h1f;
  // Rebias from 15 to 127.
  localparam logic [SGL_EXP_W-1:0]  EXP_REBIAS    = 8'd112;
  localparam logic [SGL_EXP_W-1:0]  SGL_EXP_MAX   = 8'hff;

endpackage

`default_nettype wire

>>> src/lpfw_in_if.sv
// Input channel interface: one tensor memory word plus halfword select.
// Depends on nothing.
`default_nettype none

interface lpfw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] memory_word;
  logic        half_select;

  modport source (output valid, output memory_word, output half_select, input ready);
  modport sink   (input valid, input memory_word, input half_select, output ready);
endinterface

`default_nettype wire

>>> src/lpfw_out_if.sv
// Output channel interface: one single-precision bit pattern.
// Depends on nothing.
`default_nettype none

interface lpfw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] single_bits;

  modport source (output valid, output single_bits, input ready);
  modport sink   (input valid, input single_bits, output ready);
endinterface

`default_nettype wire

>>> src/lpfw_cfg_if.sv
// Configuration write channel interface: carries the source format value.
// Depends on nothing.
`default_nettype none

interface lpfw_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] source_format;

  modport source (output valid, output source_format, input ready);
  modport sink   (input valid, input source_format, output ready);
endinterface

`default_nettype wire

>>> src/low_precision_float_widen_unit.sv
// Low-precision float widening unit: widens single, half or bfloat16 to single.
// Requests pass the stage 1, stage 2 and output registers; one request per cycle while the output is not stalled.
// Depends on lpfw_pkg, the three channel interfaces and lpfw_lzc.
// Reset (rst, synchronous, active high) empties the pipeline and sets the format to single.
// The pipeline stalls as a whole only when the output register holds a result not yet taken.
`default_nettype none

module low_precision_float_widen_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  lpfw_cfg_if.sink   cfg,
  lpfw_in_if.sink    src,
  lpfw_out_if.source dst
);
  import lpfw_pkg::*;

  // Format register. Writes are always taken; the user must write it only while idle, as the block does not enforce it.
  fmt_t source_format;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_SINGLE;
    end else if (cfg.valid) begin
      source_format <= fmt_t'(cfg.source_format);
    end
  end

  // The whole pipeline advances when the output stage is empty or being drained.
  // Bubbles in the middle stages simply travel along with their cleared valid bits.
  logic advance;
  assign advance   = !dst.valid || dst.ready;
  assign src.ready = advance;

  // Stage 1: capture the word, pick the halfword and latch the format.
  logic                v1;
  fmt_t                fmt1;
  logic [WORD_W-1:0]   word1;
  logic [HALF_W-1:0]   half1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fmt1  <= source_format;
      word1 <= src.memory_word;
      half1 <= src.half_select ? src.memory_word[WORD_W-1:HALF_W]
                               : src.memory_word[HALF_W-1:0];
    end
  end

  // Stage 2: classify the halfword and count leading zeros of its fraction.
  logic [HALF_EXP_W-1:0] expo1;
  logic [FRAC_W-1:0]     frac1;
  logic [LZC_W-1:0]      lz1;
  half_class_t           cls1;

  assign expo1 = half1[HALF_W-2:FRAC_W];
  assign frac1 = half1[FRAC_W-1:0];

  lpfw_lzc u_lzc (
    .frac  (frac1),
    .count (lz1)
  );

  always_comb begin
    if (expo1 == '0) begin
      cls1 = (frac1 == '0) ? CLS_ZERO : CLS_SUBNORMAL;
    end else if (expo1 == HALF_EXP_MAX) begin
      cls1 = CLS_SPECIAL;
    end else begin
      cls1 = CLS_NORMAL;
    end
  end

  logic              v2;
  fmt_t              fmt2;
  logic [WORD_W-1:0] word2;
  logic [HALF_W-1:0] half2;
  logic [LZC_W-1:0]  lz2;
  half_class_t       cls2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fmt2  <= fmt1;
      word2 <= word1;
      half2 <= half1;
      lz2   <= lz1;
      cls2  <= cls1;
    end
  end

  // Stage 3: normalize subnormals, rebias, and assemble the result.
  // A subnormal fraction shifts left by the zero count plus one, which drops the
  // hidden bit; its exponent is then 112 minus the zero count.
  logic                  sign2;
  logic [HALF_EXP_W-1:0] expo2;
  logic [FRAC_W-1:0]     frac2;
  logic [FRAC_W-1:0]     frac_sh;
  logic [FRAC_W-1:0]     sub_frac;
  logic [SGL_EXP_W-1:0]  sub_exp;
  logic [SGL_EXP_W-1:0]  norm_exp;
  logic [WORD_W-1:0]     half_result;
  logic [WORD_W-1:0]     result;

  assign sign2    = half2[HALF_W-1];
  assign expo2    = half2[HALF_W-2:FRAC_W];
  assign frac2    = half2[FRAC_W-1:0];
  assign frac_sh  = frac2 << lz2;
  assign sub_frac = {frac_sh[FRAC_W-2:0], 1'b0};
  assign sub_exp  = EXP_REBIAS - SGL_EXP_W'(lz2);
  assign norm_exp = SGL_EXP_W'(expo2) + EXP_REBIAS;

  always_comb begin
    unique case (cls2)
      CLS_ZERO:      half_result = {sign2, {(WORD_W-1){1'b0}}};
      CLS_SUBNORMAL: half_result = {sign2, sub_exp, sub_frac,
                                    {(SGL_FRAC_W-FRAC_W){1'b0}}};
      CLS_SPECIAL:   half_result = {sign2, SGL_EXP_MAX, frac2,
                                    {(SGL_FRAC_W-FRAC_W){1'b0}}};
      default:       half_result = {sign2, norm_exp, frac2,
                                    {(SGL_FRAC_W-FRAC_W){1'b0}}};
    endcase
  end

  always_comb begin
    unique case (fmt2)
      FMT_SINGLE: result = word2;
      FMT_HALF:   result = half_result;
      FMT_BF16:   result = {half2, {(WORD_W-HALF_W){1'b0}}};
      default:    result = '0;
    endcase
  end

  // Output register: holds a finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (advance) begin
      dst.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dst.single_bits <= result;
    end
  end

endmodule

`default_nettype wire

>>> src/lpfw_lzc.sv
// Leading-zero counter for the ten-bit half-precision fraction.
// Depends on lpfw_pkg.
`default_nettype none

module lpfw_lzc (
  input  wire logic [lpfw_pkg::FRAC_W-1:0] frac,
  output logic      [lpfw_pkg::LZC_W-1:0]  count
);
  import lpfw_pkg::*;

  // Scanning upward lets the highest set bit win. A zero input gives zero.
  always_comb begin
    count = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      if (frac[i]) begin
        count = LZC_W'(FRAC_W - 1 - i);
      end
    end
  end

endmodule

`default_nettype wire
